// ===== hw/rtl/sphere_box_overlap_classifier_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Sphere/box overlap classifier assertion macros
// Concurrent check helpers for the RTL of the classifier.
// ----------------------------------------------------------------------------
`ifndef SPHERE_BOX_OVERLAP_CLASSIFIER_UNIT_DEFINES_SVH
`define SPHERE_BOX_OVERLAP_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SBOC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sboc assertion failed");

// next-cycle implication, disabled during reset
`define SBOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sboc assertion failed");

`endif

// ===== hw/rtl/sboc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sphere/box overlap classifier package
// Shared constants, result codes and pipeline control types.
// ----------------------------------------------------------------------------
package sboc_pkg;

  localparam int LOOSE_BITS = 16;
  localparam logic [LOOSE_BITS-1:0] LOOSE_RESET = 16'd4096;
  localparam int LOOSE_FRAC = 12;
  localparam int CMP_SHIFT = 24;
  localparam int OUT_DATA_BITS = 8;

  typedef enum logic [1:0] {
    CLASS_OUTSIDE    = 2'd0,
    CLASS_INTERSECTS = 2'd1,
    CLASS_CONTAINS   = 2'd2
  } overlap_class_t;

  typedef struct packed {
    logic prod;
    logic sum;
  } sq_adv_t;

endpackage

// ===== hw/rtl/sboc_rq_square.sv =====
// ----------------------------------------------------------------------------
// Scaled radius squarer
// Two-stage square of the scaled radius: split partial products, then sum.
// ----------------------------------------------------------------------------
module sboc_rq_square #(
  parameter int RQ_W = 39
) (
  input  logic                  clk,
  input  sboc_pkg::sq_adv_t     adv,
  input  logic [RQ_W-1:0]       rq,
  output logic [2*RQ_W-1:0]     rq_sq
);

  localparam int LO_W = RQ_W / 2;
  localparam int HI_W = RQ_W - LO_W;
  localparam int SQ_W = 2 * RQ_W;

  logic [LO_W-1:0]      rq_lo;
  logic [HI_W-1:0]      rq_hi;
  logic [2*LO_W-1:0]    ll_full;
  logic [LO_W+HI_W-1:0] lh_full;
  logic [2*HI_W-1:0]    hh_full;
  logic [2*LO_W-1:0]    pp_ll;
  logic [LO_W+HI_W-1:0] pp_lh;
  logic [2*HI_W-1:0]    pp_hh;

  assign rq_lo   = rq[LO_W-1:0];
  assign rq_hi   = rq[RQ_W-1:LO_W];
  assign ll_full = (2*LO_W)'(rq_lo) * (2*LO_W)'(rq_lo);
  assign lh_full = (LO_W+HI_W)'(rq_lo) * (LO_W+HI_W)'(rq_hi);
  assign hh_full = (2*HI_W)'(rq_hi) * (2*HI_W)'(rq_hi);

  always_ff @(posedge clk) begin
    if (adv.prod) begin
      pp_ll <= ll_full;
      pp_lh <= lh_full;
      pp_hh <= hh_full;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.sum) begin
      rq_sq <= (SQ_W'(pp_hh) << (2 * LO_W)) + (SQ_W'(pp_lh) << (LO_W + 1)) + SQ_W'(pp_ll);
    end
  end

endmodule

// ===== hw/rtl/sphere_box_overlap_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// Sphere/box overlap classifier
// Classifies a sphere against an axis-aligned box as outside, intersects or
// contains, using a radius scaled by a programmable looseness factor.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one query word per beat: sphere centre, radius, box corners.
//   m_* returns one word per query holding the 2-bit overlap class.
//   cfg_wr_en/cfg_wr_data load the Q4.12 looseness factor; write it only
//   while no query is in flight.
// A query passes through the four-stage pipeline (gap and radius scale,
// squares and cube test, sums, final compare) to m_tvalid; throughput is
// one query per cycle while m_tready does not stall the output.
// Each stage holds its word while the next stage is full, so bubbles
// close up and the input keeps accepting until all four stages are
// occupied behind a stalled m_tready. Nothing is lost or repeated.
// Reset empties the pipeline and sets the looseness factor to 1.0.
// ----------------------------------------------------------------------------
`include "sphere_box_overlap_classifier_unit_defines.svh"

module sphere_box_overlap_classifier_unit #(
  parameter int COORD_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic [sboc_pkg::LOOSE_BITS-1:0]         cfg_wr_data,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // sphere_x, sphere_y, sphere_z, sphere_radius, box_min_x, box_min_y,
  // box_min_z, box_max_x, box_max_y, box_max_z, zero fill
  input  logic [((10*COORD_BITS+6)/8)*8-1:0]      s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // overlap_class, zero fill
  output logic [sboc_pkg::OUT_DATA_BITS-1:0]      m_tdata
);

  localparam int CB      = COORD_BITS;
  localparam int RAD_W   = CB - 1;
  localparam int RQ_W    = RAD_W + sboc_pkg::LOOSE_BITS;
  localparam int CW      = RQ_W + 2;
  localparam int SUM_W   = 2 * CB + 2;
  localparam int SQ_W    = 2 * RQ_W;
  localparam int OFS_RAD = 3 * CB;
  localparam int OFS_MIN = 4 * CB - 1;
  localparam int OFS_MAX = 7 * CB - 1;
  localparam int EXT_W   = CW - CB - sboc_pkg::LOOSE_FRAC;

  logic [sboc_pkg::LOOSE_BITS-1:0] lf;

  logic rdy2, rdy3, rdy4;
  logic v1, v2, v3;

  // stage 1
  logic signed [CB-1:0] c_in [3];
  logic signed [CB-1:0] mn_in [3];
  logic signed [CB-1:0] mx_in [3];
  logic signed [CB:0]   diff_lo [3];
  logic signed [CB:0]   diff_hi [3];
  logic [CB-1:0]        gap_in [3];
  logic [RAD_W-1:0]     rad_in;
  logic [RQ_W-1:0]      rq_in;
  logic signed [CB-1:0] c1 [3];
  logic signed [CB-1:0] mn1 [3];
  logic signed [CB-1:0] mx1 [3];
  logic [CB-1:0]        gap1 [3];
  logic [RQ_W-1:0]      rq1;

  // stage 2
  logic [2*CB-1:0]      sq_in [3];
  logic signed [CW-1:0] cc [3];
  logic signed [CW-1:0] mn_s [3];
  logic signed [CW-1:0] mx_s [3];
  logic signed [CW-1:0] r_s;
  logic                 in_cube;
  logic [2*CB-1:0]      sq2 [3];
  logic                 cont2;

  // stage 3
  logic [SUM_W-1:0]     sum3;
  logic                 cont3;
  logic [SQ_W-1:0]      rq_sq3;

  // stage 4
  sboc_pkg::overlap_class_t cls4;
  sboc_pkg::sq_adv_t        sq_adv;

  assign rdy4     = !m_tvalid || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign s_tready = !v1 || rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      lf <= sboc_pkg::LOOSE_RESET;
    end else if (cfg_wr_en) begin
      lf <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        v1 <= s_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        m_tvalid <= v3;
      end
    end
  end

  // stage 1: unpack, axis gaps, radius scale
  assign rad_in = s_tdata[OFS_RAD +: RAD_W];
  assign rq_in  = RQ_W'(rad_in) * RQ_W'(lf);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_in[i]    = s_tdata[i*CB +: CB];
      mn_in[i]   = s_tdata[OFS_MIN + i*CB +: CB];
      mx_in[i]   = s_tdata[OFS_MAX + i*CB +: CB];
      diff_lo[i] = {mn_in[i][CB-1], mn_in[i]} - {c_in[i][CB-1], c_in[i]};
      diff_hi[i] = {c_in[i][CB-1], c_in[i]} - {mx_in[i][CB-1], mx_in[i]};
      if (c_in[i] < mn_in[i]) begin
        gap_in[i] = diff_lo[i][CB-1:0];
      end else if (c_in[i] > mx_in[i]) begin
        gap_in[i] = diff_hi[i][CB-1:0];
      end else begin
        gap_in[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      c1   <= c_in;
      mn1  <= mn_in;
      mx1  <= mx_in;
      gap1 <= gap_in;
      rq1  <= rq_in;
    end
  end

  // stage 2: squared gaps, cube test
  assign r_s = {2'b00, rq1};

  always_comb begin
    in_cube = 1'b1;
    for (int i = 0; i < 3; i++) begin
      sq_in[i] = (2*CB)'(gap1[i]) * (2*CB)'(gap1[i]);
      cc[i]    = {{EXT_W{c1[i][CB-1]}}, c1[i], {sboc_pkg::LOOSE_FRAC{1'b0}}};
      mn_s[i]  = {{EXT_W{mn1[i][CB-1]}}, mn1[i], {sboc_pkg::LOOSE_FRAC{1'b0}}};
      mx_s[i]  = {{EXT_W{mx1[i][CB-1]}}, mx1[i], {sboc_pkg::LOOSE_FRAC{1'b0}}};
      if ((mn_s[i] < cc[i] - r_s) || (mx_s[i] > cc[i] + r_s)) begin
        in_cube = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sq2   <= sq_in;
      cont2 <= in_cube;
    end
  end

  assign sq_adv.prod = rdy2;
  assign sq_adv.sum  = rdy3;

  sboc_rq_square #(
    .RQ_W (RQ_W)
  ) u_rq_square (
    .clk   (clk),
    .adv   (sq_adv),
    .rq    (rq1),
    .rq_sq (rq_sq3)
  );

  // stage 3: sum of squares
  always_ff @(posedge clk) begin
    if (rdy3) begin
      sum3  <= SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]);
      cont3 <= cont2;
    end
  end

  // stage 4: distance compare and class
  always_ff @(posedge clk) begin
    if (rdy4) begin
      if ((SQ_W'(sum3) << sboc_pkg::CMP_SHIFT) > rq_sq3) begin
        cls4 <= sboc_pkg::CLASS_OUTSIDE;
      end else if (cont3) begin
        cls4 <= sboc_pkg::CLASS_CONTAINS;
      end else begin
        cls4 <= sboc_pkg::CLASS_INTERSECTS;
      end
    end
  end

  assign m_tdata = {{(sboc_pkg::OUT_DATA_BITS-2){1'b0}}, cls4};

  `SBOC_ASSERT_SAME(a_stall_only_when_full, clk, rst, s_tvalid && !s_tready, v1 && v2 && v3 && m_tvalid)
  `SBOC_ASSERT_NEXT(a_stage3_drains, clk, rst, v3 && rdy4, m_tvalid)
  `SBOC_ASSERT_SAME(a_empty_after_reset, clk, rst, $past(rst), !v1 && !v2 && !v3 && !m_tvalid)

endmodule

// ===== tb/sv/sphere_box_overlap_classifier_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere/box overlap classifier testbench
// Streams sphere/box queries into the classifier with bursty input and a
// stalling output, predicts each overlap class from the packed query word and
// the current looseness factor, and checks results in order. The looseness
// factor is reloaded between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module sphere_box_overlap_classifier_unit_tb;

  localparam int CB = 24;
  localparam int QW = 10 * CB - 1;
  localparam int DATA_W = ((10 * CB + 6) / 8) * 8;
  localparam longint COORD_MAX = (longint'(1) <<< (CB - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (CB - 1));
  localparam logic [CB-2:0] RAD_MAX = '1;
  localparam int RAND_PER_PHASE = 206;

  // query word, first field in the lowest bits
  typedef struct packed {
    logic signed [CB-1:0] box_max_z;
    logic signed [CB-1:0] box_max_y;
    logic signed [CB-1:0] box_max_x;
    logic signed [CB-1:0] box_min_z;
    logic signed [CB-1:0] box_min_y;
    logic signed [CB-1:0] box_min_x;
    logic [CB-2:0]        sphere_radius;
    logic signed [CB-1:0] sphere_z;
    logic signed [CB-1:0] sphere_y;
    logic signed [CB-1:0] sphere_x;
  } query_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_wr_en = 1'b0;
  logic [sboc_pkg::LOOSE_BITS-1:0]      cfg_wr_data = '0;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic [DATA_W-1:0]                    s_tdata = '0;
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic [sboc_pkg::OUT_DATA_BITS-1:0]   m_tdata;

  query_t                               query_q[$];
  sboc_pkg::overlap_class_t             class_expect_q[$];
  sboc_pkg::overlap_class_t             want_class;
  logic [sboc_pkg::LOOSE_BITS-1:0]      loose_factor = sboc_pkg::LOOSE_RESET;
  logic [sboc_pkg::LOOSE_BITS-1:0]      phase_factor [7] = '{16'd0, 16'hFFFF, 16'd1,
                                                             16'd4096, 16'd12288,
                                                             16'd2048, 16'd0};
  int                                   fail_cnt = 0;
  int                                   burst_left = 1;
  int                                   gap_left = 0;
  logic [15:0]                          ready_tick = '0;

  sphere_box_overlap_classifier_unit #(
    .COORD_BITS(CB)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic sboc_pkg::overlap_class_t classify_query(
      query_t q, logic [sboc_pkg::LOOSE_BITS-1:0] f);
    longint       cen [3];
    longint       bmin [3];
    longint       bmax [3];
    longint       gap;
    longint       r_signed;
    logic [63:0]  r_scaled;
    logic [127:0] gap_sum;
    logic [127:0] r_sq;
    bit           cube_ok;
    int           a;
    cen[0] = longint'(q.sphere_x);
    cen[1] = longint'(q.sphere_y);
    cen[2] = longint'(q.sphere_z);
    bmin[0] = longint'(q.box_min_x);
    bmin[1] = longint'(q.box_min_y);
    bmin[2] = longint'(q.box_min_z);
    bmax[0] = longint'(q.box_max_x);
    bmax[1] = longint'(q.box_max_y);
    bmax[2] = longint'(q.box_max_z);
    r_scaled = 64'(q.sphere_radius) * 64'(f);
    gap_sum = '0;
    for (a = 0; a < 3; a++) begin
      gap = 0;
      if (cen[a] < bmin[a]) begin
        gap = bmin[a] - cen[a];
      end else if (cen[a] > bmax[a]) begin
        gap = cen[a] - bmax[a];
      end
      gap_sum = gap_sum + 128'(gap * gap);
    end
    r_sq = 128'(r_scaled) * 128'(r_scaled);
    if ((gap_sum << sboc_pkg::CMP_SHIFT) > r_sq) begin
      return sboc_pkg::CLASS_OUTSIDE;
    end
    r_signed = longint'(r_scaled);
    cube_ok = 1'b1;
    for (a = 0; a < 3; a++) begin
      if (bmin[a] * 4096 < cen[a] * 4096 - r_signed ||
          bmax[a] * 4096 > cen[a] * 4096 + r_signed) begin
        cube_ok = 1'b0;
      end
    end
    return cube_ok ? sboc_pkg::CLASS_CONTAINS : sboc_pkg::CLASS_INTERSECTS;
  endfunction

  function automatic logic signed [CB-1:0] to_coord(longint v);
    if (v > COORD_MAX) begin
      return COORD_MAX[CB-1:0];
    end else if (v < COORD_MIN) begin
      return COORD_MIN[CB-1:0];
    end
    return v[CB-1:0];
  endfunction

  // offset of a box face from the centre, clustered around the scaled radius
  function automatic longint reach_pick(longint r);
    case ($urandom_range(0, 8))
      0, 1: return longint'($urandom_range(0, int'(r)));
      2: return r;
      3: return r + 1;
      4: return r - 1;
      5: return r + longint'($urandom_range(0, int'(r)));
      6: return -longint'($urandom_range(0, int'(r)));
      7: return -(r + longint'($urandom_range(1, int'(r) + 1)));
      default: return 0;
    endcase
  endfunction

  function automatic query_t make_query(logic [sboc_pkg::LOOSE_BITS-1:0] f);
    query_t               q;
    logic [255:0]         raw;
    logic [CB-2:0]        rad;
    logic signed [CB-1:0] cen [3];
    logic signed [CB-1:0] bmin [3];
    logic signed [CB-1:0] bmax [3];
    longint               reach;
    longint               c;
    longint               lo;
    longint               hi;
    longint               t;
    int                   a;
    if ($urandom_range(0, 4) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
      return query_t'(raw[QW-1:0]);
    end
    case ($urandom_range(0, 9))
      0: rad = '0;
      1, 2, 3, 4: rad = (CB-1)'($urandom_range(0, 2048));
      5, 6, 7: rad = (CB-1)'($urandom_range(0, 65536));
      8: rad = (CB-1)'($urandom);
      default: rad = RAD_MAX;
    endcase
    reach = (longint'(rad) * longint'(f)) >>> 12;
    for (a = 0; a < 3; a++) begin
      if ($urandom_range(0, 3) == 0) begin
        c = longint'($signed(CB'($urandom)));
      end else begin
        c = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
      end
      lo = c - reach_pick(reach);
      hi = c + reach_pick(reach);
      if ($urandom_range(0, 7) == 0) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      cen[a] = to_coord(c);
      bmin[a] = to_coord(lo);
      bmax[a] = to_coord(hi);
    end
    q.sphere_x = cen[0];
    q.sphere_y = cen[1];
    q.sphere_z = cen[2];
    q.sphere_radius = rad;
    q.box_min_x = bmin[0];
    q.box_min_y = bmin[1];
    q.box_min_z = bmin[2];
    q.box_max_x = bmax[0];
    q.box_max_y = bmax[1];
    q.box_max_z = bmax[2];
    return q;
  endfunction

  function automatic query_t mk(longint sx, longint sy, longint sz, longint rad,
                                longint nx, longint ny, longint nz,
                                longint xx, longint xy, longint xz);
    query_t q;
    q.sphere_x = sx[CB-1:0];
    q.sphere_y = sy[CB-1:0];
    q.sphere_z = sz[CB-1:0];
    q.sphere_radius = rad[CB-2:0];
    q.box_min_x = nx[CB-1:0];
    q.box_min_y = ny[CB-1:0];
    q.box_min_z = nz[CB-1:0];
    q.box_max_x = xx[CB-1:0];
    q.box_max_y = xy[CB-1:0];
    q.box_max_z = xz[CB-1:0];
    return q;
  endfunction

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (query_q.size() != 0 || s_tvalid || class_expect_q.size() != 0);
  endtask

  task automatic load_random(int count);
    repeat (count) query_q.push_back(make_query(loose_factor));
  endtask

  // driver: bursts of words separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        class_expect_q.push_back(classify_query(query_t'(s_tdata[QW-1:0]), loose_factor));
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (query_q.size() != 0) begin
          s_tdata <= DATA_W'(query_q.pop_front());
          s_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word, stall on a rotating pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (class_expect_q.size() == 0) begin
          $error("overlap_class: no result expected, actual %0d", m_tdata[1:0]);
          fail_cnt++;
        end else begin
          want_class = class_expect_q.pop_front();
          if (m_tdata[1:0] !== want_class) begin
            $error("overlap_class mismatch: expected %0d, actual %0d",
                   want_class, m_tdata[1:0]);
            fail_cnt++;
          end
        end
      end
      ready_tick <= ready_tick + 16'd1;
      case (ready_tick[8:7])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= 1'($urandom_range(0, 1));
        2'd2: m_tready <= ($urandom_range(0, 7) == 0);
        default: m_tready <= ready_tick[4];
      endcase
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // reset looseness of 1.0, Q16.8 coordinates (256 = 1.0)
    query_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    query_q.push_back(mk(5, -7, 9, 0, 5, -7, 9, 5, -7, 9));
    query_q.push_back(mk(0, 0, 0, 256, 256, 0, 0, 256, 0, 0));
    query_q.push_back(mk(0, 0, 0, 256, 257, 0, 0, 257, 0, 0));
    query_q.push_back(mk(0, 0, 0, 256, -256, -256, -256, 256, 256, 256));
    query_q.push_back(mk(0, 0, 0, 255, -256, -256, -256, 256, 256, 256));
    query_q.push_back(mk(0, 0, 0, 512, 100, 0, 0, -100, 0, 0));
    query_q.push_back(mk(0, 0, 0, 512, 1000, 0, 0, -1000, 0, 0));
    query_q.push_back(mk(2000, 0, 0, 512, 100, 0, 0, -100, 0, 0));
    query_q.push_back(mk(COORD_MAX, COORD_MAX, COORD_MAX, longint'(RAD_MAX), COORD_MIN,
                         COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    query_q.push_back(mk(COORD_MIN, COORD_MIN, COORD_MIN, longint'(RAD_MAX), COORD_MAX,
                         COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    query_q.push_back(mk(COORD_MIN, COORD_MIN, COORD_MIN, longint'(RAD_MAX), COORD_MIN,
                         COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    query_q.push_back(mk(COORD_MAX, COORD_MAX, COORD_MAX, 0, COORD_MIN, COORD_MIN,
                         COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    query_q.push_back(mk(0, 0, 0, 256, 128, 128, 128, 1024, 1024, 1024));
    query_q.push_back(mk(0, 0, 0, 256, 150, 150, 150, 300, 300, 300));
    query_q.push_back(mk(-1, -1, -1, longint'(RAD_MAX), -1, -1, -1, -1, -1, -1));
    load_random(RAND_PER_PHASE);
    wait_drained();
    phase_factor[6] = sboc_pkg::LOOSE_BITS'($urandom);
    foreach (phase_factor[p]) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= phase_factor[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      loose_factor = phase_factor[p];
      @(negedge clk);
      load_random(RAND_PER_PHASE);
      wait_drained();
    end
    repeat (16) @(posedge clk);
    if (fail_cnt == 0 && class_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sphere_box_overlap_classifier_unit.f =====
+incdir+hw/rtl
hw/rtl/sboc_pkg.sv
hw/rtl/sboc_rq_square.sv
hw/rtl/sphere_box_overlap_classifier_unit.sv
tb/sv/sphere_box_overlap_classifier_unit_tb.sv
